@@ sv/cascaded_position_speed_controller_core_macros.svh @@
// Assertion macros for the cascaded position/speed controller core
`ifndef CASCADED_POSITION_SPEED_CONTROLLER_CORE_MACROS_SVH
`define CASCADED_POSITION_SPEED_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ sv/cpsc_pkg.sv @@
// Types, constants and microcode table of the cascaded position/speed controller
`timescale 1ns / 1ps
package cpsc_pkg;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_OUT  = 4'd10;

  localparam logic [1:0] REG_POSITION_GAIN = 2'd0;
  localparam logic [1:0] REG_SPEED_GAIN    = 2'd1;
  localparam logic [1:0] REG_INTEGRAL_RATE = 2'd2;
  localparam logic [1:0] REG_PWM_TOP       = 2'd3;

  localparam logic [7:0]  POSITION_GAIN_RESET = 8'd16;
  localparam logic [7:0]  SPEED_GAIN_RESET    = 8'd16;
  localparam logic [7:0]  INTEGRAL_RATE_RESET = 8'd16;
  localparam logic [15:0] PWM_TOP_RESET       = 16'h07FF;

  localparam logic signed [19:0] INTEG_RESET = 20'sd3575;
  localparam logic signed [20:0] INTEG_MIN   = -21'sd524287;
  localparam logic signed [20:0] INTEG_MAX   = 21'sd524271;
  localparam logic signed [16:0] DUTY_OFFSET = 17'sd32767;

  typedef enum logic {
    A_ERR,
    A_ITERM_OFS
  } mul_a_t;

  typedef enum logic [1:0] {
    B_PGAIN,
    B_SGAIN,
    B_IRATE,
    B_TOP
  } mul_b_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_LOAD,
    WB_MUL,
    WB_SPDSET,
    WB_SPDERR,
    WB_PTERM,
    WB_INTEG,
    WB_ITERM,
    WB_OUT
  } wb_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_WAIT_IN,
    C_WAIT_OUT,
    C_JUMP
  } cond_t;

  typedef struct packed {
    mul_a_t             a_sel;
    mul_b_t             b_sel;
    wb_t                wb;
    cond_t              cond;
    logic [STEP_W-1:0]  target;
  } ucw_t;

  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '{a_sel: A_ERR, b_sel: B_PGAIN, wb: WB_NONE, cond: C_NEXT, target: STEP_IDLE};
    unique case (step)
      4'd0: begin
        w.wb   = WB_LOAD;
        w.cond = C_WAIT_IN;
      end
      4'd1: begin
        w.b_sel = B_PGAIN;
        w.wb    = WB_MUL;
      end
      4'd2: w.wb = WB_SPDSET;
      4'd3: w.wb = WB_SPDERR;
      4'd4: begin
        w.b_sel = B_SGAIN;
        w.wb    = WB_MUL;
      end
      4'd5: w.wb = WB_PTERM;
      4'd6: begin
        w.b_sel = B_IRATE;
        w.wb    = WB_MUL;
      end
      4'd7: w.wb = WB_INTEG;
      4'd8: w.wb = WB_ITERM;
      4'd9: begin
        w.a_sel = A_ITERM_OFS;
        w.b_sel = B_TOP;
        w.wb    = WB_MUL;
      end
      4'd10: begin
        w.wb     = WB_OUT;
        w.cond   = C_WAIT_OUT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = C_JUMP;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [15:0] sat16_34(input logic signed [33:0] v);
    if (v > 34'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sat16_17(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

@@ sv/cascaded_position_speed_controller_core.sv @@
// Cascaded P/PI position and speed controller, microcoded over one shared multiplier
`timescale 1ns / 1ps
`include "cascaded_position_speed_controller_core_macros.svh"
// An input word (position, target, wire_fault) is taken while the program sits
// in its entry step; the program then runs ten more steps, four of them
// passes through one shared 17x17 signed multiplier, and loads the result
// word into the output register. It takes no new word while the program
// runs; it returns to the entry step as soon as the result is loaded,
// so it accepts the next word while that result still waits for out_ready.
// A result waits in the last step only while an earlier result is still
// held. Gains and pwm_top are written over the APB port at 4*index and read
// back at the same address.
module cascaded_position_speed_controller_core
  import cpsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        position,
  input  logic [15:0]        target,
  input  logic               wire_fault,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        duty,
  output logic signed [15:0] speed_target,
  output logic signed [15:0] speed_now,
  output logic signed [15:0] prop_term,
  output logic signed [15:0] integ_term
);

  logic [7:0]  position_gain;
  logic [7:0]  speed_gain;
  logic [7:0]  integral_rate;
  logic [15:0] pwm_top;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucw_t              ucw;

  logic [15:0]        last_position;
  logic signed [19:0] integ;
  logic signed [15:0] a;
  logic signed [15:0] spd;
  logic signed [15:0] spd_set;
  logic signed [15:0] p_term;
  logic signed [15:0] i_term;
  logic               fault;
  logic signed [33:0] prod;

  logic               cfg_wr;
  logic               in_fire;
  logic               out_blocked;
  logic signed [16:0] pos_err;
  logic signed [16:0] spd_err;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic [15:0]        b_val;
  logic signed [33:0] prod_q16;
  logic signed [33:0] prod_q1024;
  logic signed [20:0] integ_sum;
  logic signed [19:0] integ_next;
  logic signed [19:0] integ_q16;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_gain <= POSITION_GAIN_RESET;
      speed_gain    <= SPEED_GAIN_RESET;
      integral_rate <= INTEGRAL_RATE_RESET;
      pwm_top       <= PWM_TOP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_POSITION_GAIN: position_gain <= pwdata[7:0];
        REG_SPEED_GAIN:    speed_gain    <= pwdata[7:0];
        REG_INTEGRAL_RATE: integral_rate <= pwdata[7:0];
        REG_PWM_TOP:       pwm_top       <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POSITION_GAIN: prdata = {24'd0, position_gain};
      REG_SPEED_GAIN:    prdata = {24'd0, speed_gain};
      REG_INTEGRAL_RATE: prdata = {24'd0, integral_rate};
      REG_PWM_TOP:       prdata = {16'd0, pwm_top};
    endcase
  end

  assign ucw         = ucode_rom(step);
  assign in_ready    = (ucw.cond == C_WAIT_IN);
  assign in_fire     = in_valid & in_ready;
  assign out_blocked = out_valid & ~out_ready;

  always_comb begin
    unique case (ucw.cond)
      C_NEXT:     step_next = step + 1'b1;
      C_WAIT_IN:  step_next = in_fire ? step + 1'b1 : step;
      C_WAIT_OUT: step_next = out_blocked ? step : ucw.target;
      C_JUMP:     step_next = ucw.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign pos_err = $signed({1'b0, target}) - $signed({1'b0, position});
  assign spd_err = $signed({spd_set[15], spd_set}) - $signed({spd[15], spd});

  always_comb begin
    unique case (ucw.b_sel)
      B_PGAIN: b_val = {8'd0, position_gain};
      B_SGAIN: b_val = {8'd0, speed_gain};
      B_IRATE: b_val = {8'd0, integral_rate};
      B_TOP:   b_val = pwm_top;
    endcase
  end

  always_comb begin
    unique case (ucw.a_sel)
      A_ERR:       mul_a = {a[15], a};
      A_ITERM_OFS: mul_a = $signed({i_term[15], i_term}) + DUTY_OFFSET;
    endcase
  end

  assign mul_b = $signed({1'b0, b_val});

  assign prod_q16   = (prod + (prod[33] ? 34'sd15 : 34'sd0)) >>> 4;
  assign prod_q1024 = (prod + (prod[33] ? 34'sd1023 : 34'sd0)) >>> 10;
  assign integ_sum  = $signed({integ[19], integ}) + prod_q1024[20:0];
  assign integ_q16  = (integ + (integ[19] ? 20'sd15 : 20'sd0)) >>> 4;

  always_comb begin
    if (fault) begin
      integ_next = '0;
    end else if (integ_sum > INTEG_MAX) begin
      integ_next = INTEG_MAX[19:0];
    end else if (integ_sum < INTEG_MIN) begin
      integ_next = INTEG_MIN[19:0];
    end else begin
      integ_next = integ_sum[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position <= '0;
      integ         <= INTEG_RESET;
    end else begin
      if (ucw.wb == WB_LOAD && in_fire) begin
        last_position <= position;
      end
      if (ucw.wb == WB_INTEG) begin
        integ <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ucw.wb)
      WB_LOAD: begin
        a     <= sat16_17(pos_err);
        spd   <= position - last_position;
        fault <= wire_fault;
      end
      WB_MUL:    prod    <= mul_a * mul_b;
      WB_SPDSET: spd_set <= sat16_34(prod_q16);
      WB_SPDERR: a       <= sat16_17(spd_err);
      WB_PTERM: begin
        p_term <= sat16_34(prod_q16);
        a      <= sat16_34(prod_q16);
      end
      WB_ITERM: i_term <= integ_q16[15:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ucw.wb == WB_OUT && !out_blocked) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ucw.wb == WB_OUT && !out_blocked) begin
      duty         <= prod[31:16];
      speed_target <= spd_set;
      speed_now    <= spd;
      prop_term    <= p_term;
      integ_term   <= i_term;
    end
  end

  `ASSERT_NEXT(a_accept_advances, clk, rst, in_fire, step == STEP_IDLE + 1'b1, "accepted word did not start the program")
  `ASSERT_ALWAYS(a_integ_range, clk, rst, (integ >= INTEG_MIN) && (integ <= INTEG_MAX), "integrator out of range")
  `ASSERT_IMPLY(a_out_from_last_step, clk, rst, $rose(out_valid), $past(step) == STEP_OUT, "result loaded outside the output step")
  `ASSERT_IMPLY(a_duty_below_top, clk, rst, out_valid, (duty < pwm_top) || (pwm_top == 16'd0), "duty not below pwm_top")

endmodule

@@ test/cpsc_result_checker.sv @@
// Checker that predicts and compares every result word of the position/speed controller
`timescale 1ns / 1ps
module cpsc_result_checker
  import cpsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        position,
  input  logic [15:0]        target,
  input  logic               wire_fault,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        duty,
  input  logic signed [15:0] speed_target,
  input  logic signed [15:0] speed_now,
  input  logic signed [15:0] prop_term,
  input  logic signed [15:0] integ_term,
  output int                 pending,
  output int                 fail_count,
  output int                 n_checked,
  output int                 n_fault,
  output int                 n_top,
  output int                 n_bottom
);

  localparam int ACC_START = 3575;
  localparam int ACC_HI    = 524271;
  localparam int ACC_LO    = -524287;

  typedef struct packed {
    logic [15:0] duty;
    logic [15:0] spd_target;
    logic [15:0] spd_now;
    logic [15:0] p_term;
    logic [15:0] i_term;
  } tick_result_t;

  int           pos_gain;
  int           spd_gain;
  int           int_rate;
  int           top_count;
  logic [15:0]  prev_pos;
  int           integ_acc;
  tick_result_t expected_ticks[$];

  initial begin
    pending    = 0;
    fail_count = 0;
    n_checked  = 0;
    n_fault    = 0;
    n_top      = 0;
    n_bottom   = 0;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic tick_result_t run_control_tick(input logic [15:0] pos, input logic [15:0] tgt,
                                                    input logic flt);
    int           ipos;
    int           itgt;
    int           pos_err;
    int           spd_set;
    int           spd;
    int           spd_err;
    int           p;
    int           acc;
    int           iterm;
    int           lim;
    longint       prod;
    logic [15:0]  delta;
    tick_result_t r;
    ipos    = pos;
    itgt    = tgt;
    pos_err = clamp16(itgt - ipos);
    spd_set = clamp16(pos_err * pos_gain / 16);
    delta   = pos - prev_pos;
    spd     = $signed(delta);
    prev_pos = pos;
    spd_err = clamp16(spd_set - spd);
    p       = clamp16(spd_err * spd_gain / 16);
    acc     = integ_acc + p * int_rate / 1024;
    if (acc > ACC_HI) acc = ACC_HI;
    if (acc < ACC_LO) acc = ACC_LO;
    if (flt) acc = 0;
    integ_acc = acc;
    if (acc == ACC_HI) n_top++;
    if (acc == ACC_LO) n_bottom++;
    iterm = integ_acc / 16;
    lim   = iterm;
    if (lim > 32767) lim = 32767;
    if (lim < -32767) lim = -32767;
    prod  = longint'(lim + 32767) * longint'(top_count);
    r.duty       = prod[31:16];
    r.spd_target = spd_set[15:0];
    r.spd_now    = spd[15:0];
    r.p_term     = p[15:0];
    r.i_term     = iterm[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (rst) begin
      pos_gain  = POSITION_GAIN_RESET;
      spd_gain  = SPEED_GAIN_RESET;
      int_rate  = INTEGRAL_RATE_RESET;
      top_count = PWM_TOP_RESET;
      prev_pos  = '0;
      integ_acc = ACC_START;
      expected_ticks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_POSITION_GAIN: pos_gain = pwdata[7:0];
          REG_SPEED_GAIN:    spd_gain = pwdata[7:0];
          REG_INTEGRAL_RATE: int_rate = pwdata[7:0];
          REG_PWM_TOP:       top_count = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word: duty %0d", duty);
        end else begin
          want = expected_ticks.pop_front();
          n_checked++;
          if (duty !== want.duty || speed_target !== want.spd_target ||
              speed_now !== want.spd_now || prop_term !== want.p_term ||
              integ_term !== want.i_term) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("word %0d mismatch (expected/actual): duty %0d/%0d spd_target %0d/%0d",
                       n_checked, want.duty, duty, $signed(want.spd_target), speed_target);
              $display("  spd_now %0d/%0d p_term %0d/%0d i_term %0d/%0d",
                       $signed(want.spd_now), speed_now, $signed(want.p_term), prop_term,
                       $signed(want.i_term), integ_term);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (wire_fault) n_fault++;
        expected_ticks.push_back(run_control_tick(position, target, wire_fault));
      end
    end
    pending = expected_ticks.size();
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the cascaded position/speed controller core
`timescale 1ns / 1ps
module tb;
  import cpsc_pkg::*;

  typedef enum logic [1:0] {
    SEG_NOISE,
    SEG_HOLD,
    SEG_SETTLE
  } seg_mode_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        position;
  logic [15:0]        target;
  logic               wire_fault;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        duty;
  logic signed [15:0] speed_target;
  logic signed [15:0] speed_now;
  logic signed [15:0] prop_term;
  logic signed [15:0] integ_term;

  int pending;
  int fail_count;
  int n_checked;
  int n_fault;
  int n_top;
  int n_bottom;

  int          burst_left;
  int          seg_left;
  seg_mode_t   seg_mode;
  logic [15:0] seg_tgt;
  logic [15:0] seg_pos;
  logic [15:0] stall_pat;
  int          stall_left;

  cascaded_position_speed_controller_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .position(position), .target(target), .wire_fault(wire_fault),
    .out_valid(out_valid), .out_ready(out_ready),
    .duty(duty), .speed_target(speed_target), .speed_now(speed_now),
    .prop_term(prop_term), .integ_term(integ_term)
  );

  cpsc_result_checker u_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .position(position), .target(target), .wire_fault(wire_fault),
    .out_valid(out_valid), .out_ready(out_ready),
    .duty(duty), .speed_target(speed_target), .speed_now(speed_now),
    .prop_term(prop_term), .integ_term(integ_term),
    .pending(pending), .fail_count(fail_count), .n_checked(n_checked),
    .n_fault(n_fault), .n_top(n_top), .n_bottom(n_bottom)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[cascaded_position_speed_controller_core] ERROR");
    $finish;
  end

  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    stall_pat  = '0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_pat  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        stall_left = 64;
      end
      out_ready = stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      stall_left--;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_tick(input logic [15:0] p, input logic [15:0] t, input logic f);
    in_valid   = 1'b1;
    position   = p;
    target     = t;
    wire_fault = f;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic send_random_tick();
    int diff;
    int jitter;
    logic [15:0] p;
    logic [15:0] t;
    logic f;
    if (seg_left == 0) begin
      case ($urandom_range(0, 3))
        0: seg_mode = SEG_NOISE;
        1: seg_mode = SEG_SETTLE;
        default: seg_mode = SEG_HOLD;
      endcase
      seg_left = $urandom_range(5, 80);
      seg_tgt  = 16'($urandom);
      seg_pos  = 16'($urandom);
    end
    seg_left--;
    case (seg_mode)
      SEG_NOISE: begin
        p = 16'($urandom);
        t = 16'($urandom);
        f = 1'($urandom_range(0, 1));
      end
      SEG_HOLD: begin
        jitter  = $urandom_range(0, 64);
        seg_pos = seg_pos + 16'(jitter - 32);
        p = seg_pos;
        t = seg_tgt;
        f = ($urandom_range(0, 40) == 0);
      end
      default: begin
        diff    = int'(seg_tgt) - int'(seg_pos);
        jitter  = $urandom_range(0, 16);
        jitter  = jitter - 8;
        seg_pos = 16'(int'(seg_pos) + diff / 4 + jitter);
        p = seg_pos;
        t = seg_tgt;
        f = ($urandom_range(0, 40) == 0);
      end
    endcase
    send_tick(p, t, f);
  endtask

  initial begin
    int pg;
    int sg;
    int ir;
    int top;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    position   = '0;
    target     = '0;
    wire_fault = 1'b0;
    burst_left = 0;
    seg_left   = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_tick(16'h0000, 16'h0000, 1'b0);
    send_tick(16'h0000, 16'hFFFF, 1'b0);
    send_tick(16'hFFFF, 16'h0000, 1'b0);
    send_tick(16'h0000, 16'h0000, 1'b0);
    send_tick(16'h8000, 16'h7FFF, 1'b0);
    send_tick(16'h7FFF, 16'h8000, 1'b0);
    send_tick(16'h0000, 16'h8000, 1'b0);
    send_tick(16'h8000, 16'h0000, 1'b0);
    send_tick(16'hFFFF, 16'hFFFF, 1'b1);
    send_tick(16'hFFFF, 16'hFFFF, 1'b0);
    send_tick(16'd12345, 16'd54321, 1'b1);
    send_tick(16'd54321, 16'd12345, 1'b0);
    send_tick(16'hFFFF, 16'h0000, 1'b1);
    send_tick(16'h0000, 16'hFFFF, 1'b1);
    send_tick(16'hAAAA, 16'h5555, 1'b0);
    send_tick(16'h5555, 16'hAAAA, 1'b1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin pg = 255; sg = 255; ir = 255; top = 65535; end
        1: begin pg = 0;   sg = 0;   ir = 0;   top = 1;     end
        2: begin pg = 16;  sg = 16;  ir = 255; top = 0;     end
        3: begin pg = 255; sg = 255; ir = 255; top = 1;     end
        default: begin
          pg  = $urandom_range(0, 255);
          sg  = $urandom_range(0, 255);
          ir  = $urandom_range(0, 255);
          top = $urandom_range(1, 65535);
        end
      endcase
      write_reg(REG_POSITION_GAIN, pg);
      write_reg(REG_SPEED_GAIN, sg);
      write_reg(REG_INTEGRAL_RATE, ir);
      write_reg(REG_PWM_TOP, top);
      repeat (122) send_random_tick();
      drain();
    end

    $display("Checked %0d result words over reset defaults and 7 gain settings, %0d with wire fault.",
             n_checked, n_fault);
    $display("Integrator reached its upper limit %0d times and its lower limit %0d times.",
             n_top, n_bottom);
    if (fail_count == 0 && pending == 0) begin
      $display("[cascaded_position_speed_controller_core] OK");
    end else begin
      $display("[cascaded_position_speed_controller_core] ERROR");
    end
    $finish;
  end

endmodule

@@ cascaded_position_speed_controller_core.f @@
+incdir+sv
sv/cpsc_pkg.sv
sv/cascaded_position_speed_controller_core.sv
test/cpsc_result_checker.sv
test/tb.sv
